### rtl/csd_pkg.sv
`default_nettype none
package csd_pkg;

  // Configuration register indexes.
  localparam logic [3:0] REG_INV_LOAD_MASS   = 4'd0;
  localparam logic [3:0] REG_INV_CAR_MASS    = 4'd1;
  localparam logic [3:0] REG_SPRING_CONSTANT = 4'd2;
  localparam logic [3:0] REG_DAMPING_COEFF   = 4'd3;
  localparam logic [3:0] REG_FORCE_LIMIT     = 4'd4;
  localparam logic [3:0] REG_SPEED_LIMIT     = 4'd5;
  localparam logic [3:0] REG_SUBSTEP_SIZE    = 4'd6;
  localparam logic [3:0] REG_SUBSTEP_COUNT   = 4'd7;

  // Register reset values.
  localparam logic [30:0] RST_INV_LOAD_MASS   = 31'd6554;
  localparam logic [30:0] RST_INV_CAR_MASS    = 31'd655;
  localparam logic [30:0] RST_SPRING_CONSTANT = 31'd983040;
  localparam logic [30:0] RST_DAMPING_COEFF   = 31'd655360;
  localparam logic [30:0] RST_FORCE_LIMIT     = 31'd1966080;
  localparam logic [30:0] RST_SPEED_LIMIT     = 31'd65536;
  localparam logic [30:0] RST_SUBSTEP_SIZE    = 31'd66;
  localparam logic [6:0]  RST_SUBSTEP_COUNT   = 7'd10;

  // ceil(2^34 / 6): exact division by six of any 32-bit magnitude after >> 34.
  localparam logic signed [32:0] DIV6_RECIP = 33'sh0AAAAAAAB;
  localparam logic signed [65:0] Q_HALF     = 66'sd32768;
  localparam logic signed [65:0] SAT_HI     = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO     = -66'sd2147483648;

  typedef struct packed {
    logic [30:0] inv_load_mass;
    logic [30:0] inv_car_mass;
    logic [30:0] spring_constant;
    logic [30:0] damping_coeff;
    logic [30:0] force_limit;
    logic [30:0] speed_limit;
    logic [30:0] substep_size;
  } cfg_t;

  // Multiplier operations of the datapath.
  typedef enum logic [2:0] {
    OP_SK,
    OP_CD,
    OP_LOAD,
    OP_CART,
    OP_POINT,
    OP_FMUL,
    OP_FDIV
  } op_t;

  typedef struct packed {
    logic       load_item;
    logic       start_sub;
    logic       mul_en;
    logic       wb_en;
    logic       acc_en;
    logic       end_sub;
    logic       capture_out;
    op_t        op;
    logic [1:0] idx;
    logic [1:0] stage;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] load_position;
    logic signed [31:0] load_speed;
    logic signed [31:0] cart_position;
    logic signed [31:0] cart_speed;
  } result_t;

  // Saturate a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/csd_if.sv
`default_nettype none
interface csd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_command;
  modport source (output valid, output force_command, input ready);
  modport sink (input valid, input force_command, output ready);
endinterface

interface csd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] load_position;
  logic signed [31:0] load_speed;
  logic signed [31:0] cart_position;
  logic signed [31:0] cart_speed;
  modport source (output valid, output load_position, output load_speed,
                  output cart_position, output cart_speed, input ready);
  modport sink (input valid, input load_position, input load_speed,
                input cart_position, input cart_speed, output ready);
endinterface
`default_nettype wire

### rtl/crane_spring_damper_rk4_plant_top.sv
`default_nettype none
// Crane plant simulator: a cart and its load joined by a rope spring and
// damper, advanced by classic RK4 substeps in saturating signed Q16.16. Each
// input beat is a force command; it is clamped to the force limit and then
// substep_count substeps (capped at MAX_SUBSTEPS) are run, after which one
// output beat carries the load and cart position and speed. All products
// go through one shared, registered 33 x 33 multiplier; a substep consists of
// four derivative evaluations, three stage points and the final update. With a
// substep count of zero the state is returned unchanged. A new command is
// taken while the previous result still waits in the output register.
// Configuration is to be written only while the block is idle: the user is
// bound by this, and the block itself does not enforce it. Writes to an index
// above 7 are ignored.
module crane_spring_damper_rk4_plant_top #(
  parameter int MAX_SUBSTEPS = 64
) (
  input  wire         clk,
  input  wire         rst,
  csd_in_if.sink      in_ch,
  csd_out_if.source   out_ch,
  input  wire         cfg_write,
  input  wire [3:0]   cfg_index,
  input  wire [30:0]  cfg_data
);
  import csd_pkg::*;

  cfg_t        cfg;
  logic [6:0]  substep_count;
  cmd_t        cmd;
  result_t     result;
  logic        in_ready, out_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_load_mass   <= RST_INV_LOAD_MASS;
      cfg.inv_car_mass    <= RST_INV_CAR_MASS;
      cfg.spring_constant <= RST_SPRING_CONSTANT;
      cfg.damping_coeff   <= RST_DAMPING_COEFF;
      cfg.force_limit     <= RST_FORCE_LIMIT;
      cfg.speed_limit     <= RST_SPEED_LIMIT;
      cfg.substep_size    <= RST_SUBSTEP_SIZE;
      substep_count       <= RST_SUBSTEP_COUNT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INV_LOAD_MASS:   cfg.inv_load_mass   <= cfg_data;
        REG_INV_CAR_MASS:    cfg.inv_car_mass    <= cfg_data;
        REG_SPRING_CONSTANT: cfg.spring_constant <= cfg_data;
        REG_DAMPING_COEFF:   cfg.damping_coeff   <= cfg_data;
        REG_FORCE_LIMIT:     cfg.force_limit     <= cfg_data;
        REG_SPEED_LIMIT:     cfg.speed_limit     <= cfg_data;
        REG_SUBSTEP_SIZE:    cfg.substep_size    <= cfg_data;
        REG_SUBSTEP_COUNT:   substep_count       <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  csd_ctrl #(
    .MAX_SUBSTEPS(MAX_SUBSTEPS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .substep_count(substep_count),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ready),
    .out_ready    (out_ch.ready),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  csd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .force_command(in_ch.force_command),
    .result       (result)
  );

  // Channel hookup.
  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.load_position = result.load_position;
  assign out_ch.load_speed    = result.load_speed;
  assign out_ch.cart_position = result.cart_position;
  assign out_ch.cart_speed    = result.cart_speed;

endmodule
`default_nettype wire

### rtl/csd_dp.sv
`default_nettype none
module csd_dp (
  input  wire                 clk,
  input  wire                 rst,
  input  csd_pkg::cfg_t       cfg,
  input  csd_pkg::cmd_t       cmd,
  input  wire signed [31:0]   force_command,
  output csd_pkg::result_t    result
);
  import csd_pkg::*;

  logic signed [31:0] y [4];
  logic signed [31:0] t [4];
  logic signed [31:0] kc [4];
  logic signed [34:0] acc [4];
  logic signed [31:0] sk, cd, mq, u, f, applied_force;
  logic signed [65:0] prod;

  logic signed [32:0] ma, mb;
  logic signed [31:0] dp_w, dv_w, e_w, g_w, fsel, s_w, res;
  logic signed [31:0] kv [4];
  logic signed [32:0] lim, vlim, cmd_w, h_w, hh_w, mq_abs, qd;
  logic signed [31:0] u_next, f_next;
  logic               wt2;

  // Derivative terms from the current stage point.
  always_comb begin
    fsel  = (cmd.stage == 2'd0) ? applied_force : f;
    dp_w  = sat32(66'(t[0]) - 66'(t[2]));
    dv_w  = sat32(66'(t[1]) - 66'(t[3]));
    e_w   = sat32(-66'(sk) - 66'(cd));
    g_w   = sat32(66'(sk) + 66'(cd) + 66'(fsel));
    s_w   = sat32(66'(acc[cmd.idx]));
    h_w   = $signed({2'b00, cfg.substep_size});
    hh_w  = $signed({3'b000, cfg.substep_size[30:1]});
    mq_abs = mq[31] ? -33'(mq) : 33'(mq);
    res   = sat32((prod + Q_HALF) >>> 16);
    qd    = mq[31] ? -$signed({1'b0, prod[65:34]}) : $signed({1'b0, prod[65:34]});
    kv[0] = t[1];
    kv[1] = kc[1];
    kv[2] = t[3];
    kv[3] = kc[3];
    wt2   = (cmd.stage == 2'd1) || (cmd.stage == 2'd2);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.op)
      OP_SK: begin
        ma = $signed({2'b00, cfg.spring_constant});
        mb = 33'(dp_w);
      end
      OP_CD: begin
        ma = $signed({2'b00, cfg.damping_coeff});
        mb = 33'(dv_w);
      end
      OP_LOAD: begin
        ma = $signed({2'b00, cfg.inv_load_mass});
        mb = 33'(e_w);
      end
      OP_CART: begin
        ma = $signed({2'b00, cfg.inv_car_mass});
        mb = 33'(g_w);
      end
      OP_POINT: begin
        ma = 33'(kc[cmd.idx]);
        mb = (cmd.stage == 2'd2) ? h_w : hh_w;
      end
      OP_FMUL: begin
        ma = 33'(s_w);
        mb = h_w;
      end
      OP_FDIV: begin
        ma = mq_abs;
        mb = DIV6_RECIP;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Clamped command and speed-limit cut.
  always_comb begin
    lim   = $signed({2'b00, cfg.force_limit});
    vlim  = $signed({2'b00, cfg.speed_limit});
    cmd_w = 33'(force_command);
    if (cmd_w > lim) begin
      u_next = lim[31:0];
    end else if (cmd_w < -lim) begin
      u_next = 32'(-lim);
    end else begin
      u_next = force_command;
    end
    f_next = u;
    if ((33'(y[3]) >= vlim) && (u > 32'sd0)) begin
      f_next = '0;
    end else if ((33'(y[3]) <= -vlim) && (u < 32'sd0)) begin
      f_next = '0;
    end
  end

  // Multiplier register.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= ma * mb;
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      u <= u_next;
    end
    if (cmd.start_sub) begin
      f <= f_next;
      for (int i = 0; i < 4; i++) begin
        t[i] <= y[i];
      end
    end
    if (cmd.wb_en) begin
      case (cmd.op)
        OP_SK:    sk <= res;
        OP_CD:    cd <= res;
        OP_LOAD:  kc[1] <= res;
        OP_CART:  kc[3] <= res;
        OP_POINT: t[cmd.idx] <= sat32(66'(y[cmd.idx]) + 66'(res));
        OP_FMUL:  mq <= res;
        default: begin
        end
      endcase
    end
    if (cmd.acc_en) begin
      kc[0] <= t[1];
      kc[2] <= t[3];
      for (int i = 0; i < 4; i++) begin
        acc[i] <= ((cmd.stage == 2'd0) ? 35'sd0 : acc[i])
                + (wt2 ? (35'(kv[i]) <<< 1) : 35'(kv[i]));
      end
    end
    if (cmd.capture_out) begin
      result.load_position <= y[0];
      result.load_speed    <= y[1];
      result.cart_position <= y[2];
      result.cart_speed    <= y[3];
    end
  end

  // Plant state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        y[i] <= '0;
      end
      applied_force <= '0;
    end else begin
      if (cmd.wb_en && (cmd.op == OP_FDIV)) begin
        y[cmd.idx] <= sat32(66'(y[cmd.idx]) + 66'(qd));
      end
      if (cmd.end_sub) begin
        applied_force <= f;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/csd_ctrl.sv
`default_nettype none
module csd_ctrl #(
  parameter int MAX_SUBSTEPS = 64
) (
  input  wire              clk,
  input  wire              rst,
  input  wire [6:0]        substep_count,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire              out_ready,
  output logic             out_valid,
  output csd_pkg::cmd_t    cmd
);
  import csd_pkg::*;

  localparam int NW = $clog2(MAX_SUBSTEPS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_WB    = 7'b0001000,
    S_ACC   = 7'b0010000,
    S_END   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    PH_DERIV,
    PH_POINT,
    PH_FMUL,
    PH_FDIV
  } phase_t;

  state_t        state, state_next;
  phase_t        phase, phase_next;
  logic [1:0]    idx, idx_next, stage, stage_next;
  logic [NW-1:0] nsub, nsub_next, ncount, ncount_next, count_eff;
  logic          out_valid_next;

  always_comb begin
    if (32'(substep_count) > 32'(MAX_SUBSTEPS)) begin
      count_eff = NW'(MAX_SUBSTEPS);
    end else begin
      count_eff = NW'(substep_count);
    end
  end

  // Sequencer.
  always_comb begin
    state_next  = state;
    phase_next  = phase;
    idx_next    = idx;
    stage_next  = stage;
    nsub_next   = nsub;
    ncount_next = ncount;
    out_valid_next = out_valid && !out_ready;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.idx     = idx;
    cmd.stage   = stage;
    case (phase)
      PH_DERIV: begin
        case (idx)
          2'd0:    cmd.op = OP_SK;
          2'd1:    cmd.op = OP_CD;
          2'd2:    cmd.op = OP_LOAD;
          default: cmd.op = OP_CART;
        endcase
      end
      PH_POINT: cmd.op = OP_POINT;
      PH_FMUL:  cmd.op = OP_FMUL;
      default:  cmd.op = OP_FDIV;
    endcase

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          ncount_next   = count_eff;
          nsub_next     = '0;
          state_next    = (count_eff == '0) ? S_OUT : S_START;
        end
      end
      S_START: begin
        cmd.start_sub = 1'b1;
        phase_next    = PH_DERIV;
        idx_next      = 2'd0;
        stage_next    = 2'd0;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        cmd.wb_en  = 1'b1;
        state_next = S_MUL;
        case (phase)
          PH_DERIV: begin
            if (idx == 2'd3) begin
              state_next = S_ACC;
            end else begin
              idx_next = idx + 2'd1;
            end
          end
          PH_POINT: begin
            if (idx == 2'd3) begin
              phase_next = PH_DERIV;
              idx_next   = 2'd0;
              stage_next = stage + 2'd1;
            end else begin
              idx_next = idx + 2'd1;
            end
          end
          PH_FMUL: begin
            phase_next = PH_FDIV;
          end
          default: begin
            if (idx == 2'd3) begin
              state_next = S_END;
            end else begin
              phase_next = PH_FMUL;
              idx_next   = idx + 2'd1;
            end
          end
        endcase
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        idx_next   = 2'd0;
        phase_next = (stage == 2'd3) ? PH_FMUL : PH_POINT;
        state_next = S_MUL;
      end
      S_END: begin
        cmd.end_sub = 1'b1;
        nsub_next   = nsub + NW'(1);
        state_next  = (nsub + NW'(1) == ncount) ? S_OUT : S_START;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.capture_out = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_DERIV;
      idx       <= '0;
      stage     <= '0;
      nsub      <= '0;
      ncount    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      idx       <= idx_next;
      stage     <= stage_next;
      nsub      <= nsub_next;
      ncount    <= ncount_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire
